/* rtl/mkphr_pkg.sv */
package mkphr_pkg;

  // fixed field widths
  localparam int unsigned PortFieldW   = 16;
  localparam int unsigned PortWidthDef = 16;
  localparam int unsigned CountW       = 8;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned AlignW       = 8;
  localparam int unsigned ApbAddrW     = 4;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned InDataW      = 32;
  localparam int unsigned OutDataW     = 16;

  // register reset values
  localparam logic [PortFieldW-1:0] RowMaskRst      = 16'h00ff;
  localparam logic [PortFieldW-1:0] ColMaskRst      = 16'hff00;
  localparam logic [CountW-1:0]     ReleaseTicksRst = 8'd5;
  localparam logic [CountW-1:0]     HoldTicksRst    = 8'd100;
  localparam logic [CountW-1:0]     CountMax        = 8'hff;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ROW_MASK      = 2'd0,
    REG_COL_MASK      = 2'd1,
    REG_RELEASE_TICKS = 2'd2,
    REG_HOLD_TICKS    = 2'd3
  } reg_idx_e;

  // input item kind
  localparam logic OP_ROW_EVENT = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  // reported event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PRESSED  = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;
  localparam logic [1:0] EV_HELD     = 2'd3;

  // reported state codes
  localparam logic [1:0] ST_RELEASED = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_HELD     = 2'd2;

  typedef enum logic [2:0] {
    MODE_RELEASED = 3'b001,
    MODE_PRESSED  = 3'b010,
    MODE_HELD     = 3'b100
  } mode_e;

  typedef struct packed {
    logic [PortFieldW-1:0] row_mask;
    logic [PortFieldW-1:0] col_mask;
    logic [CountW-1:0]     release_ticks;
    logic [CountW-1:0]     hold_ticks;
  } cfg_t;

  // port bits that exist on the pins
  function automatic logic [PortFieldW-1:0] keep_bits(int unsigned pw);
    logic [PortFieldW-1:0] k;
    k = '0;
    for (int unsigned i = 0; i < PortFieldW; i++) begin
      if (i < pw) k[i] = 1'b1;
    end
    return k;
  endfunction

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    case (m)
      MODE_PRESSED: c = ST_PRESSED;
      MODE_HELD:    c = ST_HELD;
      default:      c = ST_RELEASED;
    endcase
    return c;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] c);
    return (c == CountMax) ? CountMax : c + CountW'(1);
  endfunction

endpackage

/* rtl/mkphr_align.sv */
module mkphr_align #(
  parameter int unsigned PORT_WIDTH = mkphr_pkg::PortWidthDef
) (
  input  logic [mkphr_pkg::PortFieldW-1:0] port_i,
  input  logic [mkphr_pkg::PortFieldW-1:0] mask_i,
  output logic [mkphr_pkg::IdxW-1:0]       idx_o
);
  import mkphr_pkg::*;

  localparam logic [PortFieldW-1:0] Keep = keep_bits(PORT_WIDTH);

  logic [PortFieldW-1:0] mask_k;
  logic [PortFieldW-1:0] port_k;
  logic [$clog2(PortFieldW)-1:0] shift;
  logic [PortFieldW-1:0] shifted;
  logic [AlignW-1:0] aligned;

  assign mask_k = mask_i & Keep;
  assign port_k = port_i & Keep;

  // lowest set mask bit, zero shift for an empty mask
  always_comb begin
    shift = '0;
    for (int i = PortFieldW - 1; i >= 0; i--) begin
      if (mask_k[i]) shift = ($clog2(PortFieldW))'(i);
    end
  end

  assign shifted = port_k >> shift;
  assign aligned = shifted[AlignW-1:0];

  always_comb begin
    idx_o = IdxW'(AlignW);
    for (int i = AlignW - 1; i >= 0; i--) begin
      if (aligned[i]) idx_o = IdxW'(i);
    end
  end

endmodule

/* rtl/mkphr_regs.sv */
module mkphr_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mkphr_pkg::ApbAddrW-1:0]    paddr,
  input  logic [mkphr_pkg::ApbDataW-1:0]    pwdata,
  output logic [mkphr_pkg::ApbDataW-1:0]    prdata,
  output mkphr_pkg::cfg_t                   cfg_o
);
  import mkphr_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_mask      <= RowMaskRst;
      cfg_q.col_mask      <= ColMaskRst;
      cfg_q.release_ticks <= ReleaseTicksRst;
      cfg_q.hold_ticks    <= HoldTicksRst;
    end else if (wr_en) begin
      case (idx)
        REG_ROW_MASK:      cfg_q.row_mask      <= pwdata[PortFieldW-1:0];
        REG_COL_MASK:      cfg_q.col_mask      <= pwdata[PortFieldW-1:0];
        REG_RELEASE_TICKS: cfg_q.release_ticks <= pwdata[CountW-1:0];
        REG_HOLD_TICKS:    cfg_q.hold_ticks    <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_MASK:      prdata = ApbDataW'(cfg_q.row_mask);
      REG_COL_MASK:      prdata = ApbDataW'(cfg_q.col_mask);
      REG_RELEASE_TICKS: prdata = ApbDataW'(cfg_q.release_ticks);
      REG_HOLD_TICKS:    prdata = ApbDataW'(cfg_q.hold_ticks);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/matrix_keypad_press_hold_release.sv */
// an accepted input beat passes the input register, then the result register, to the master side
// throughput: one beat per cycle unless the result stalls, set by the single compute
//   stage between input and result registers (state updates in that one step)
// reset: rst_ni is asynchronous active low; it returns the key to released,
//   clears the counters and key position and loads the register defaults
module matrix_keypad_press_hold_release #(
  parameter int unsigned PORT_WIDTH = mkphr_pkg::PortWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mkphr_pkg::ApbAddrW-1:0]      paddr,
  input  logic [mkphr_pkg::ApbDataW-1:0]      pwdata,
  output logic [mkphr_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mkphr_pkg::InDataW-1:0]       s_axis_tdata,  // row_port, col_port
  input  logic                                s_axis_tuser,  // operation
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mkphr_pkg::OutDataW-1:0]      m_axis_tdata   // key_event, key_state,
                                                             // key_row, key_col, pad
);
  import mkphr_pkg::*;

  localparam logic [PortFieldW-1:0] Keep = keep_bits(PORT_WIDTH);

  cfg_t cfg;

  // register file, write at the access phase, reads are combinational
  mkphr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  // input register
  logic                  in_vld_q;
  logic                  op_q;
  logic [PortFieldW-1:0] row_q;
  logic [PortFieldW-1:0] col_q;

  // result register
  logic                  out_vld_q;
  logic [1:0]            ev_q,  ev_d;
  logic [1:0]            st_q;

  // key state
  mode_e                 mode_q, mode_d;
  logic [CountW-1:0]     open_q, open_d;
  logic [CountW-1:0]     press_q, press_d;
  logic [IdxW-1:0]       row_idx_q, row_idx_d;
  logic [IdxW-1:0]       col_idx_q, col_idx_d;

  logic advance;
  logic in_take;

  // the input stage moves on whenever the result register is free or draining
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= s_axis_tuser;
      row_q <= s_axis_tdata[PortFieldW-1:0];
      col_q <= s_axis_tdata[2*PortFieldW-1:PortFieldW];
    end
  end

  // key position from the aligned ports
  logic [IdxW-1:0] row_idx_new, col_idx_new;

  mkphr_align #(.PORT_WIDTH(PORT_WIDTH)) u_align_row (
    .port_i (row_q),
    .mask_i (cfg.row_mask),
    .idx_o  (row_idx_new)
  );

  mkphr_align #(.PORT_WIDTH(PORT_WIDTH)) u_align_col (
    .port_i (col_q),
    .mask_i (cfg.col_mask),
    .idx_o  (col_idx_new)
  );

  logic              rows_any;
  logic              cols_idle;
  logic [CountW-1:0] press_inc;
  logic [CountW-1:0] open_inc;

  assign rows_any  = |(row_q & Keep);
  assign cols_idle = ~|(col_q & Keep);
  assign press_inc = sat_inc(press_q);
  assign open_inc  = cols_idle ? sat_inc(open_q) : open_q;

  always_comb begin
    mode_d    = mode_q;
    open_d    = open_q;
    press_d   = press_q;
    row_idx_d = row_idx_q;
    col_idx_d = col_idx_q;
    ev_d      = EV_NONE;
    if (op_q == OP_ROW_EVENT) begin
      // a press is only taken from the released state with some row line set
      if (mode_q == MODE_RELEASED && rows_any) begin
        row_idx_d = row_idx_new;
        col_idx_d = col_idx_new;
        open_d    = '0;
        press_d   = '0;
        mode_d    = MODE_PRESSED;
        ev_d      = EV_PRESSED;
      end
    end else if (mode_q != MODE_RELEASED) begin
      press_d = press_inc;
      open_d  = open_inc;
      // release has priority over hold on the same tick
      if (open_inc >= cfg.release_ticks) begin
        open_d  = '0;
        press_d = '0;
        mode_d  = MODE_RELEASED;
        ev_d    = EV_RELEASED;
      end else if (press_inc >= cfg.hold_ticks) begin
        press_d = '0;
        mode_d  = MODE_HELD;
        ev_d    = EV_HELD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RELEASED;
      open_q    <= '0;
      press_q   <= '0;
      row_idx_q <= '0;
      col_idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        mode_q    <= mode_d;
        open_q    <= open_d;
        press_q   <= press_d;
        row_idx_q <= row_idx_d;
        col_idx_q <= col_idx_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload; key position is read back from the state registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q <= ev_d;
      st_q <= mode_code(mode_d);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, col_idx_q, row_idx_q, st_q, ev_q};

endmodule

/* rtl/mkphr_checker.sv */
module mkphr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mkphr_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mkphr_pkg::*;

  logic [1:0]      ev;
  logic [1:0]      st;
  logic [IdxW-1:0] rw;
  logic [IdxW-1:0] cl;

  assign ev = m_axis_tdata[1:0];
  assign st = m_axis_tdata[3:2];
  assign rw = m_axis_tdata[7:4];
  assign cl = m_axis_tdata[11:8];

  // a stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // a press leaves the key pressed
  a_press_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ev == EV_PRESSED |-> st == ST_PRESSED)
    else $error("press reported with wrong state");

  // a hold leaves the key held, a release leaves it released
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ev == EV_HELD |-> st == ST_HELD)
    else $error("hold reported with wrong state");

  a_release_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ev == EV_RELEASED |-> st == ST_RELEASED)
    else $error("release reported with wrong state");

  // key position never exceeds the eight lines plus the none code
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> rw <= IdxW'(AlignW) && cl <= IdxW'(AlignW))
    else $error("key position out of range");

endmodule

bind matrix_keypad_press_hold_release mkphr_checker u_mkphr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/matrix_keypad_press_hold_release_tb.sv */
module matrix_keypad_press_hold_release_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mkphr_pkg::*;

  // cycles with no beat and no register write before the run is called dead
  localparam int unsigned QuietLimit   = 2000;
  // receiver back-pressure stretch used to fill the pipeline
  localparam int unsigned RxHoldCycles = 80;
  // settling margin after the last result beat is back
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned ScriptLen    = 21;
  localparam int unsigned PhaseCount   = 9;

  // one result beat, split into its fields
  typedef struct packed {
    logic [1:0] ev;
    logic [1:0] st;
    logic [3:0] row;
    logic [3:0] col;
  } key_report_t;

  // rides along with each input beat: a hand-typed result overrides the tracker
  typedef struct packed {
    logic        typed;
    key_report_t want;
  } beat_note_t;

  typedef struct packed {
    logic        op;
    logic [15:0] rows;
    logic [15:0] cols;
    logic        typed;
    key_report_t want;
  } script_row_t;

  // opening sequence, run with the register defaults
  // (row mask 0x00ff, column mask 0xff00, release after 5 idle ticks, hold at 100)
  localparam script_row_t Script [0:ScriptLen-1] = '{
    // tick while released is ignored
    '{OP_TICK,      16'h0000, 16'h0000, 1'b1, '{EV_NONE,    ST_RELEASED, 4'd0, 4'd0}},
    // row event with an empty row port is ignored
    '{OP_ROW_EVENT, 16'h0000, 16'hffff, 1'b1, '{EV_NONE,    ST_RELEASED, 4'd0, 4'd0}},
    // nothing left in the low byte after alignment: index 8 on both sides
    '{OP_ROW_EVENT, 16'hff00, 16'h00ff, 1'b1, '{EV_PRESSED, ST_PRESSED,  4'd8, 4'd8}},
    // row event while pressed is ignored
    '{OP_ROW_EVENT, 16'hffff, 16'hffff, 1'b1, '{EV_NONE,    ST_PRESSED,  4'd8, 4'd8}},
    // idle ticks are cumulative, busy ticks in between do not clear them
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'hffff, 16'hffff, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'h1234, 16'h0001, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'hffff, 16'h0000, 1'b1, '{EV_NONE,    ST_RELEASED, 4'd8, 4'd8}},
    // top bits of both windows
    '{OP_ROW_EVENT, 16'h0080, 16'h8000, 1'b1, '{EV_PRESSED, ST_PRESSED,  4'd7, 4'd7}},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    '{OP_TICK,      16'h0000, 16'h0000, 1'b0, '0},
    // all ones: lowest bit of each window wins
    '{OP_ROW_EVENT, 16'hffff, 16'hffff, 1'b1, '{EV_PRESSED, ST_PRESSED,  4'd0, 4'd0}},
    '{OP_ROW_EVENT, 16'h0001, 16'h0100, 1'b1, '{EV_NONE,    ST_PRESSED,  4'd0, 4'd0}},
    '{OP_TICK,      16'h5555, 16'haaaa, 1'b0, '0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // row_port, col_port
  logic                s_axis_tuser  = 1'b0;  // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // key_event, key_state, key_row, key_col, pad

  // tracker copy of the registers
  logic [15:0] row_mask_q  = RowMaskRst;
  logic [15:0] col_mask_q  = ColMaskRst;
  logic [7:0]  release_lim = ReleaseTicksRst;
  logic [7:0]  hold_lim    = HoldTicksRst;

  // tracker copy of the key state
  logic [1:0]  key_mode    = ST_RELEASED;
  logic [7:0]  open_ticks  = '0;
  logic [7:0]  press_ticks = '0;
  logic [3:0]  key_row     = '0;
  logic [3:0]  key_col     = '0;

  beat_note_t  beat_notes[$];
  key_report_t key_reports_due[$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // pacing knobs, percent of cycles spent idle
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  // long receiver hold-off: bumped by the stimulus, granted by the receiver
  int unsigned hold_requests = 0;
  int unsigned hold_granted  = 0;
  int unsigned rx_hold_left  = 0;

  matrix_keypad_press_hold_release #(
    .PORT_WIDTH(PortWidthDef)
  ) uut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  // shift the port down by the mask's lowest set bit, then find the lowest
  // set bit of the low byte (8 when there is none)
  function automatic logic [3:0] key_index(logic [15:0] port, logic [15:0] mask);
    int unsigned sh;
    logic [15:0] aligned;
    logic [3:0]  idx;
    sh = 0;
    for (int i = 15; i >= 0; i--) begin
      if (mask[i]) sh = i;
    end
    aligned = port >> sh;
    idx = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (aligned[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  // press / hold / release tracking for one accepted input beat
  function automatic key_report_t track_key(logic op, logic [15:0] rows, logic [15:0] cols);
    key_report_t rep;
    rep.ev = EV_NONE;
    if (op == OP_ROW_EVENT) begin
      if (key_mode == ST_RELEASED && rows != '0) begin
        key_row     = key_index(rows, row_mask_q);
        key_col     = key_index(cols, col_mask_q);
        open_ticks  = '0;
        press_ticks = '0;
        key_mode    = ST_PRESSED;
        rep.ev      = EV_PRESSED;
      end
    end else if (key_mode != ST_RELEASED) begin
      // both counters stick at their top value
      if (press_ticks != CountMax) press_ticks = press_ticks + 8'd1;
      if (cols == '0 && open_ticks != CountMax) open_ticks = open_ticks + 8'd1;
      // release takes priority over hold on the same tick
      if (open_ticks >= release_lim) begin
        open_ticks  = '0;
        press_ticks = '0;
        key_mode    = ST_RELEASED;
        rep.ev      = EV_RELEASED;
      end else if (press_ticks >= hold_lim) begin
        press_ticks = '0;
        key_mode    = ST_HELD;
        rep.ev      = EV_HELD;
      end
    end
    rep.st  = key_mode;
    rep.row = key_row;
    rep.col = key_col;
    return rep;
  endfunction

  // everything sampled here sees the values from just before the edge
  always @(posedge clk_i) begin : monitor
    key_report_t got;
    key_report_t want;
    beat_note_t  note;
    if (rst_ni) begin
      quiet_cycles++;
      // result side first: a beat going in this edge cannot come out this edge
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got.ev  = m_axis_tdata[1:0];
        got.st  = m_axis_tdata[3:2];
        got.row = m_axis_tdata[7:4];
        got.col = m_axis_tdata[11:8];
        if (key_reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected result beat: ev %0d st %0d row %0d col %0d",
                     got.ev, got.st, got.row, got.col);
          end
        end else begin
          want = key_reports_due.pop_front();
          if (got.ev !== want.ev || got.st !== want.st ||
              got.row !== want.row || got.col !== want.col) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("mismatch ev/st/row/col: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.ev, want.st, want.row, want.col,
                       got.ev, got.st, got.row, got.col);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        note = beat_notes.pop_front();
        want = track_key(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
        if (note.typed) want = note.want;
        key_reports_due.push_back(want);
      end
      if (psel && penable && pwrite && pready) begin
        quiet_cycles = 0;
        case (reg_idx_e'(paddr[3:2]))
          REG_ROW_MASK:      row_mask_q  = pwdata[15:0];
          REG_COL_MASK:      col_mask_q  = pwdata[15:0];
          REG_RELEASE_TICKS: release_lim = pwdata[7:0];
          REG_HOLD_TICKS:    hold_lim    = pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else if (hold_requests != hold_granted) begin
      hold_granted  <= hold_requests;
      rx_hold_left  <= RxHoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ends the run when nothing has moved for too long
  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("matrix_keypad_press_hold_release regression: fail");
    $finish;
  end

  // offer one input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic op, input logic [15:0] rows, input logic [15:0] cols,
                           input beat_note_t note);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    beat_notes.push_back(note);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cols, rows};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait until every result beat is back
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (key_reports_due.size() != 0 || beat_notes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // setup phase, access phase, then the bus is parked
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    beat_note_t  note;
    logic [15:0] rows;
    logic [15:0] cols;
    logic [15:0] rmask;
    logic [15:0] cmask;
    logic [7:0]  rel;
    logic [7:0]  hold;
    int unsigned budget;
    int unsigned sent;
    int unsigned span;
    int unsigned col_idle;
    int unsigned ticks;
    int unsigned pick;
    int unsigned pause_at;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening with default registers
    for (int i = 0; i < ScriptLen; i++) begin
      note.typed = Script[i].typed;
      note.want  = Script[i].want;
      send_beat(Script[i].op, Script[i].rows, Script[i].cols, note);
    end
    drain_reports();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      // sender-light / receiver-heavy, then swapped, then free running
      if (ph < 3) begin
        tx_idle_pct = 28;
        rx_idle_pct = 51;
      end else if (ph < 6) begin
        tx_idle_pct = 51;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      case (ph)
        0: begin
          // full masks, release and hold counts of one
          rmask = 16'hffff; cmask = 16'hffff; rel = 8'd1; hold = 8'd1;
          span = 4; col_idle = 50; budget = 50;
        end
        1: begin
          // empty masks (no shift), longest release and hold racing each other
          rmask = 16'h0000; cmask = 16'h0000; rel = 8'd255; hold = 8'd255;
          span = 270; col_idle = 97; budget = 270;
        end
        2: begin
          rmask = 16'h0001; cmask = 16'h8000; rel = 8'd3; hold = 8'd4;
          span = 10; col_idle = 30; budget = 60;
        end
        3: begin
          // zero release count: first tick while pressed releases
          rmask = 16'($urandom); cmask = 16'($urandom); rel = 8'd0; hold = 8'd2;
          span = 3; col_idle = 50; budget = 40;
        end
        4: begin
          // zero hold count: every tick that does not release is a hold
          rmask = 16'($urandom); cmask = 16'($urandom); rel = 8'd6; hold = 8'd0;
          span = 10; col_idle = 40; budget = 50;
        end
        5: begin
          rmask = 16'h00f0; cmask = 16'h0f00; rel = 8'd2; hold = 8'd3;
          span = 8; col_idle = 40; budget = 50;
        end
        default: begin
          rmask = 16'($urandom); cmask = 16'($urandom);
          rel = 8'($urandom_range(1, 8)); hold = 8'($urandom_range(1, 10));
          span = 14; col_idle = 50; budget = 60;
        end
      endcase

      // block is idle here: every result of the previous phase is back
      write_reg(REG_ROW_MASK, rmask);
      write_reg(REG_COL_MASK, cmask);
      write_reg(REG_RELEASE_TICKS, 16'(rel));
      write_reg(REG_HOLD_TICKS, 16'(hold));

      // receiver holds off while the sender keeps pushing: input must stall
      if (ph == 6) hold_requests++;
      // halfway through this phase the sender waits for an empty pipeline
      pause_at = (ph == 5) ? budget / 2 : budget + 1;

      sent = 0;
      while (sent < budget) begin
        if (sent >= pause_at) begin
          drain_reports();
          pause_at = budget + 1;
        end
        // key press: half the time a single row line, now and then an empty row port, else random lines
        pick = $urandom_range(9);
        if (pick == 0) begin
          rows = '0;
        end else if (pick < 6) begin
          rows = 16'h0001 << $urandom_range(15);
        end else begin
          rows = 16'($urandom);
          if (rows == '0) rows = 16'h8000;
        end
        cols = (pick < 6) ? (16'h0001 << $urandom_range(15)) : 16'($urandom);
        note = '0;
        send_beat(OP_ROW_EVENT, rows, cols, note);

        // ticks while the key is down, with some stray row events mixed in
        ticks = $urandom_range(span / 2, span);
        // keep the phase within its beat budget
        if (ticks > budget - sent - 1) ticks = budget - sent - 1;
        repeat (ticks) begin
          rows = 16'($urandom);
          cols = ($urandom_range(99) < col_idle) ? 16'h0000 : 16'($urandom);
          if ($urandom_range(9) == 0) begin
            send_beat(OP_ROW_EVENT, rows, cols, note);
          end else begin
            send_beat(OP_TICK, rows, cols, note);
          end
        end
        sent += 1 + ticks;
      end
      drain_reports();
    end

    if (mismatches == 0 && key_reports_due.size() == 0) begin
      $display("matrix_keypad_press_hold_release regression: pass");
    end else begin
      $display("matrix_keypad_press_hold_release regression: fail");
    end
    $finish;
  end

endmodule
